@@ hw/rtl/djsm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the DMA job slot manager.
// No dependencies; the controller, datapath and top level refer to this package.
package djsm_pkg;

   localparam int SLOT_COUNT_DEF = 16;
   localparam int ID_OUT_W       = 4;

   typedef enum logic [1:0] {
      CMD_SUBMIT  = 2'd0,
      CMD_RUN     = 2'd1,
      CMD_COLLECT = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_LOCKED   = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOT_DONE = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      OP_NONE       = 4'd0,
      OP_CAPTURE    = 4'd1,
      OP_SUB_FAIL   = 4'd2,
      OP_FREE_RD    = 4'd3,
      OP_SUB_COMMIT = 4'd4,
      OP_RUN_EMPTY  = 4'd5,
      OP_PEND_RD    = 4'd6,
      OP_DESC_RD    = 4'd7,
      OP_RUN_COMMIT = 4'd8,
      OP_COLLECT    = 4'd9
   } op_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] src_addr;
      logic [31:0] trg_addr;
      logic [23:0] copy_length;
      logic        src_read_lock;
      logic        trg_write_lock;
      logic [3:0]  job_id;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  slot_id;
      logic        issue_valid;
      logic [31:0] issue_src;
      logic [31:0] issue_trg;
      logic [23:0] issue_length;
   } rsp_type;

   typedef struct packed {
      logic [31:0] src;
      logic [31:0] trg;
      logic [23:0] length;
      logic [1:0]  locks;
   } desc_type;

   localparam int DESC_W = $bits(desc_type);

   typedef struct packed {
      op_type op;
   } ctl_cmd_type;

   typedef struct packed {
      cmd_type command;
      logic    free_none;
      logic    pend_empty;
      logic    rsp_busy;
   } ctl_stat_type;

endpackage

@@ hw/rtl/djsm_req_if.sv @@
`timescale 1ns / 1ps
// Command channel of the DMA job slot manager: valid/ready plus command payload.
// Standalone; field widths are fixed.
interface djsm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] src_addr;
   logic [31:0] trg_addr;
   logic [23:0] copy_length;
   logic        src_read_lock;
   logic        trg_write_lock;
   logic [3:0]  job_id;

   modport source (
      output valid, command, src_addr, trg_addr, copy_length,
             src_read_lock, trg_write_lock, job_id,
      input  ready
   );
   modport sink (
      input  valid, command, src_addr, trg_addr, copy_length,
             src_read_lock, trg_write_lock, job_id,
      output ready
   );
endinterface

@@ hw/rtl/djsm_rsp_if.sv @@
`timescale 1ns / 1ps
// Result channel of the DMA job slot manager: valid/ready plus result payload.
// Standalone; field widths are fixed.
interface djsm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [3:0]  slot_id;
   logic        issue_valid;
   logic [31:0] issue_src;
   logic [31:0] issue_trg;
   logic [23:0] issue_length;

   modport source (
      output valid, status, slot_id, issue_valid, issue_src, issue_trg, issue_length,
      input  ready
   );
   modport sink (
      input  valid, status, slot_id, issue_valid, issue_src, issue_trg, issue_length,
      output ready
   );
endinterface

@@ hw/rtl/djsm_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone.
module djsm_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/djsm_dpath.sv @@
`timescale 1ns / 1ps
// Datapath of the DMA job slot manager: slot stacks, descriptor store, done marks,
// counters and the result register. Uses djsm_pkg and djsm_ram.
module djsm_dpath #(
   parameter int SLOT_COUNT = djsm_pkg::SLOT_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  djsm_pkg::ctl_cmd_type  ctl_cmd,
   output djsm_pkg::ctl_stat_type ctl_stat,
   input  djsm_pkg::req_type      req_data,
   output djsm_pkg::rsp_type      rsp_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready
);

   localparam int IDW = $clog2(SLOT_COUNT);
   localparam int CW  = $clog2(SLOT_COUNT + 1);
   localparam int JW  = (IDW > djsm_pkg::ID_OUT_W) ? IDW : djsm_pkg::ID_OUT_W;

   djsm_pkg::req_type  req_ff, req_in;
   djsm_pkg::rsp_type  rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]      free_count_ff, free_count_in;
   logic [CW-1:0]      pend_count_ff, pend_count_in;
   logic [SLOT_COUNT-1:0] free_vld_ff, free_vld_in;
   logic [SLOT_COUNT-1:0] done_ff, done_in;
   logic [IDW-1:0]     free_dflt_ff, free_dflt_in;
   logic               free_sel_vld_ff, free_sel_vld_in;
   logic [IDW-1:0]     run_id_ff, run_id_in;

   logic               free_wr_en, free_rd_en;
   logic [IDW-1:0]     free_wr_addr, free_rd_addr, free_wr_data, free_q;
   logic               pend_wr_en, pend_rd_en;
   logic [IDW-1:0]     pend_wr_addr, pend_rd_addr, pend_wr_data, pend_q;
   logic               desc_wr_en, desc_rd_en;
   logic [IDW-1:0]     desc_wr_addr, desc_rd_addr;
   djsm_pkg::desc_type desc_wr_data, desc_q;

   logic [CW-1:0]      free_top, pend_top;
   logic [IDW-1:0]     sub_id;
   logic [JW-1:0]      jid_w;
   logic [IDW-1:0]     jid_idx;
   logic               jid_ok;
   logic [31:0]        dflt_full;

   function automatic logic [3:0] id_out(input logic [IDW-1:0] id);
      logic [JW-1:0] w;
      w = JW'(id);
      return w[3:0];
   endfunction

   djsm_ram #(.WIDTH(IDW), .DEPTH(SLOT_COUNT)) u_free_ram (
      .clock   (clock),
      .wr_en   (free_wr_en),
      .wr_addr (free_wr_addr),
      .wr_data (free_wr_data),
      .rd_en   (free_rd_en),
      .rd_addr (free_rd_addr),
      .rd_data (free_q)
   );

   djsm_ram #(.WIDTH(IDW), .DEPTH(SLOT_COUNT)) u_pend_ram (
      .clock   (clock),
      .wr_en   (pend_wr_en),
      .wr_addr (pend_wr_addr),
      .wr_data (pend_wr_data),
      .rd_en   (pend_rd_en),
      .rd_addr (pend_rd_addr),
      .rd_data (pend_q)
   );

   djsm_ram #(.WIDTH(djsm_pkg::DESC_W), .DEPTH(SLOT_COUNT)) u_desc_ram (
      .clock   (clock),
      .wr_en   (desc_wr_en),
      .wr_addr (desc_wr_addr),
      .wr_data (desc_wr_data),
      .rd_en   (desc_rd_en),
      .rd_addr (desc_rd_addr),
      .rd_data (desc_q)
   );

   assign free_top  = free_count_ff - CW'(1);
   assign pend_top  = pend_count_ff - CW'(1);
   assign dflt_full = 32'(SLOT_COUNT) - 32'(free_count_ff);
   // never-pushed entries of the free stack hold their reset id
   assign sub_id    = free_sel_vld_ff ? free_q : free_dflt_ff;
   assign jid_w     = JW'(req_ff.job_id);
   assign jid_idx   = jid_w[IDW-1:0];
   assign jid_ok    = (32'(req_ff.job_id) < 32'(SLOT_COUNT)) && done_ff[jid_idx] &&
                      (free_count_ff < CW'(SLOT_COUNT));

   always_comb begin
      req_in          = req_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff;
      free_count_in   = free_count_ff;
      pend_count_in   = pend_count_ff;
      free_vld_in     = free_vld_ff;
      done_in         = done_ff;
      free_dflt_in    = free_dflt_ff;
      free_sel_vld_in = free_sel_vld_ff;
      run_id_in       = run_id_ff;

      free_wr_en   = 1'b0;
      free_wr_addr = free_count_ff[IDW-1:0];
      free_wr_data = jid_idx;
      free_rd_en   = 1'b0;
      free_rd_addr = free_top[IDW-1:0];
      pend_wr_en   = 1'b0;
      pend_wr_addr = pend_count_ff[IDW-1:0];
      pend_wr_data = sub_id;
      pend_rd_en   = 1'b0;
      pend_rd_addr = pend_top[IDW-1:0];
      desc_wr_en   = 1'b0;
      desc_wr_addr = sub_id;
      desc_wr_data.src    = req_ff.src_addr;
      desc_wr_data.trg    = req_ff.trg_addr;
      desc_wr_data.length = req_ff.copy_length;
      desc_wr_data.locks  = {req_ff.trg_write_lock, req_ff.src_read_lock};
      desc_rd_en   = 1'b0;
      desc_rd_addr = pend_q;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (ctl_cmd.op)
         djsm_pkg::OP_CAPTURE: begin
            req_in = req_data;
         end
         djsm_pkg::OP_SUB_FAIL: begin
            rsp_in        = '0;
            rsp_in.status = djsm_pkg::ST_FULL;
            rsp_valid_in  = 1'b1;
         end
         djsm_pkg::OP_FREE_RD: begin
            free_rd_en      = 1'b1;
            free_sel_vld_in = free_vld_ff[free_top[IDW-1:0]];
            free_dflt_in    = dflt_full[IDW-1:0];
         end
         djsm_pkg::OP_SUB_COMMIT: begin
            desc_wr_en      = 1'b1;
            pend_wr_en      = 1'b1;
            done_in[sub_id] = 1'b0;
            free_count_in   = free_count_ff - CW'(1);
            pend_count_in   = pend_count_ff + CW'(1);
            rsp_in          = '0;
            rsp_in.status   = djsm_pkg::ST_OK;
            rsp_in.slot_id  = id_out(sub_id);
            rsp_valid_in    = 1'b1;
         end
         djsm_pkg::OP_RUN_EMPTY: begin
            rsp_in        = '0;
            rsp_in.status = djsm_pkg::ST_EMPTY;
            rsp_valid_in  = 1'b1;
         end
         djsm_pkg::OP_PEND_RD: begin
            pend_rd_en = 1'b1;
         end
         djsm_pkg::OP_DESC_RD: begin
            desc_rd_en = 1'b1;
            run_id_in  = pend_q;
         end
         djsm_pkg::OP_RUN_COMMIT: begin
            rsp_in         = '0;
            rsp_in.slot_id = id_out(run_id_ff);
            rsp_valid_in   = 1'b1;
            if (desc_q.locks != 2'b00) begin
               rsp_in.status = djsm_pkg::ST_LOCKED;
            end else begin
               rsp_in.status       = djsm_pkg::ST_OK;
               rsp_in.issue_valid  = 1'b1;
               rsp_in.issue_src    = desc_q.src;
               rsp_in.issue_trg    = desc_q.trg;
               rsp_in.issue_length = desc_q.length;
               done_in[run_id_ff]  = 1'b1;
               pend_count_in       = pend_count_ff - CW'(1);
            end
         end
         djsm_pkg::OP_COLLECT: begin
            rsp_in         = '0;
            rsp_in.slot_id = req_ff.job_id;
            rsp_valid_in   = 1'b1;
            if (jid_ok) begin
               rsp_in.status                       = djsm_pkg::ST_OK;
               done_in[jid_idx]                    = 1'b0;
               free_wr_en                          = 1'b1;
               free_vld_in[free_count_ff[IDW-1:0]] = 1'b1;
               free_count_in                       = free_count_ff + CW'(1);
            end else begin
               rsp_in.status = djsm_pkg::ST_NOT_DONE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         free_count_ff <= CW'(SLOT_COUNT);
         pend_count_ff <= '0;
         free_vld_ff   <= '0;
         done_ff       <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         free_count_ff <= free_count_in;
         pend_count_ff <= pend_count_in;
         free_vld_ff   <= free_vld_in;
         done_ff       <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff          <= req_in;
      rsp_ff          <= rsp_in;
      free_dflt_ff    <= free_dflt_in;
      free_sel_vld_ff <= free_sel_vld_in;
      run_id_ff       <= run_id_in;
   end

   assign ctl_stat.command    = djsm_pkg::cmd_type'(req_ff.command);
   assign ctl_stat.free_none  = (free_count_ff == '0) || (pend_count_ff >= CW'(SLOT_COUNT));
   assign ctl_stat.pend_empty = (pend_count_ff == '0);
   assign ctl_stat.rsp_busy   = rsp_valid_ff;

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hw/rtl/djsm_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the DMA job slot manager: sequences each command beat into
// datapath operations. Uses djsm_pkg.
module djsm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  djsm_pkg::ctl_stat_type ctl_stat,
   output djsm_pkg::ctl_cmd_type  ctl_cmd
);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_DISPATCH = 5'b00010,
      S_SUB      = 5'b00100,
      S_RUN_ID   = 5'b01000,
      S_RUN_FIN  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      ctl_cmd.op = djsm_pkg::OP_NONE;
      req_ready  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl_cmd.op = djsm_pkg::OP_CAPTURE;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (ctl_stat.command)
               djsm_pkg::CMD_SUBMIT: begin
                  if (!ctl_stat.free_none) begin
                     ctl_cmd.op = djsm_pkg::OP_FREE_RD;
                     state_in   = S_SUB;
                  end else if (!ctl_stat.rsp_busy) begin
                     ctl_cmd.op = djsm_pkg::OP_SUB_FAIL;
                     state_in   = S_IDLE;
                  end
               end
               djsm_pkg::CMD_RUN: begin
                  if (!ctl_stat.pend_empty) begin
                     ctl_cmd.op = djsm_pkg::OP_PEND_RD;
                     state_in   = S_RUN_ID;
                  end else if (!ctl_stat.rsp_busy) begin
                     ctl_cmd.op = djsm_pkg::OP_RUN_EMPTY;
                     state_in   = S_IDLE;
                  end
               end
               djsm_pkg::CMD_COLLECT: begin
                  if (!ctl_stat.rsp_busy) begin
                     ctl_cmd.op = djsm_pkg::OP_COLLECT;
                     state_in   = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SUB: begin
            if (!ctl_stat.rsp_busy) begin
               ctl_cmd.op = djsm_pkg::OP_SUB_COMMIT;
               state_in   = S_IDLE;
            end
         end
         S_RUN_ID: begin
            ctl_cmd.op = djsm_pkg::OP_DESC_RD;
            state_in   = S_RUN_FIN;
         end
         S_RUN_FIN: begin
            if (!ctl_stat.rsp_busy) begin
               ctl_cmd.op = djsm_pkg::OP_RUN_COMMIT;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/dma_job_slot_manager_unit.sv @@
`timescale 1ns / 1ps
// Top level of the DMA job slot manager: controller, datapath and checks.
// Uses djsm_pkg, djsm_req_if, djsm_rsp_if, djsm_ctrl and djsm_dpath.
//
// req_bus carries command beats (submit, run, collect); rsp_bus returns one
// result beat per command 0..2, command 3 is dropped without a result.
// One command is in flight at a time. req_bus.ready is high only while the
// controller is idle. A collect, a failed submit or an empty run is committed
// straight from dispatch; a submit first reads the free stack and a run the
// pending stack and then the descriptor RAM, as these reads are registered.
// A new beat is taken only once the controller is back in idle after the
// previous command's commit, or after dispatch for command 3.
// A finished result sits in the output register; the next command is
// accepted meanwhile and only its commit waits while that register is full.
// Reset (synchronous) puts all slots on the free stack with slot 0 on top,
// empties the pending stack and clears all done marks; no clearing pass.
module dma_job_slot_manager_unit #(
   parameter int SLOT_COUNT = djsm_pkg::SLOT_COUNT_DEF
) (
   input logic          clock,
   input logic          reset,
   djsm_req_if.sink     req_bus,
   djsm_rsp_if.source   rsp_bus
);

   djsm_pkg::ctl_cmd_type  ctl_cmd;
   djsm_pkg::ctl_stat_type ctl_stat;
   djsm_pkg::req_type      req_data;
   djsm_pkg::rsp_type      rsp_data;
   logic                   rsp_valid;
   logic                   req_ready;
   logic                   commit_op;

   assign req_data.command        = req_bus.command;
   assign req_data.src_addr       = req_bus.src_addr;
   assign req_data.trg_addr       = req_bus.trg_addr;
   assign req_data.copy_length    = req_bus.copy_length;
   assign req_data.src_read_lock  = req_bus.src_read_lock;
   assign req_data.trg_write_lock = req_bus.trg_write_lock;
   assign req_data.job_id         = req_bus.job_id;
   assign req_bus.ready           = req_ready;

   djsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .ctl_stat  (ctl_stat),
      .ctl_cmd   (ctl_cmd)
   );

   djsm_dpath #(.SLOT_COUNT(SLOT_COUNT)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctl_cmd   (ctl_cmd),
      .ctl_stat  (ctl_stat),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready)
   );

   assign rsp_bus.valid        = rsp_valid;
   assign rsp_bus.status       = rsp_data.status;
   assign rsp_bus.slot_id      = rsp_data.slot_id;
   assign rsp_bus.issue_valid  = rsp_data.issue_valid;
   assign rsp_bus.issue_src    = rsp_data.issue_src;
   assign rsp_bus.issue_trg    = rsp_data.issue_trg;
   assign rsp_bus.issue_length = rsp_data.issue_length;

   assign commit_op = (ctl_cmd.op == djsm_pkg::OP_SUB_FAIL)   ||
                      (ctl_cmd.op == djsm_pkg::OP_SUB_COMMIT) ||
                      (ctl_cmd.op == djsm_pkg::OP_RUN_EMPTY)  ||
                      (ctl_cmd.op == djsm_pkg::OP_RUN_COMMIT) ||
                      (ctl_cmd.op == djsm_pkg::OP_COLLECT);

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      commit_op |-> !ctl_stat.rsp_busy)
      else $error("result committed while output register full");

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      commit_op |=> rsp_bus.valid)
      else $error("committed result not presented");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("second command accepted while one in flight");

   a_issue_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.issue_valid) |-> (rsp_bus.status == djsm_pkg::ST_OK))
      else $error("descriptor issued with non-ok status");

endmodule
